[src/tlbfifo_pkg.sv]
`default_nettype none

package tlbfifo_pkg;

    localparam int TLB_ENTRIES = 16;
    localparam int PAGE_BITS   = 8;
    localparam int OFFSET_BITS = 8;
    localparam int ADDR_BITS   = PAGE_BITS + OFFSET_BITS;
    localparam int PAGE_COUNT  = 1 << PAGE_BITS;
    // queue slot carries either the offset (translate) or the frame (load)
    localparam int DATA_BITS   = (PAGE_BITS > OFFSET_BITS) ? PAGE_BITS : OFFSET_BITS;
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic
    {
        CMD_LOAD  = 1'b0,
        CMD_XLATE = 1'b1
    } cmd_e;

    typedef struct packed
    {
        logic                 command;
        logic [ADDR_BITS-1:0] logical_address;
        logic [PAGE_BITS-1:0] load_page;
        logic [PAGE_BITS-1:0] load_frame;
    } request_t;

    typedef struct packed
    {
        logic [ADDR_BITS-1:0] physical_address;
        logic                 tlb_hit;
    } result_t;

    // classified item as held in the queue
    typedef struct packed
    {
        cmd_e                 kind;
        logic [PAGE_BITS-1:0] page;
        logic [DATA_BITS-1:0] data;
    } entry_t;

    typedef struct packed
    {
        logic   valid;
        entry_t entry;
    } head_t;

endpackage : tlbfifo_pkg

`default_nettype wire

[src/tlb_fifo_address_translator_top.sv]
// TLB with FIFO replacement in front of a 256-entry page table.
//
// Command channel: an item is taken at a rising edge with start high and
// busy low. command = 1 translates logical_address (page = high byte,
// offset = low byte); command = 0 writes load_frame into the page table
// at load_page and gives no result.
// Result channel: done is high for exactly one cycle with physical_address
// (frame : offset) and tlb_hit on result. There is no back-pressure.
// A translate is written into the queue, popped into the item register
// with the page table read, and its result is then registered with done.
// The back end does a translate as a registered page table read issued
// at dequeue, then TLB search and update, and pops no new item meanwhile;
// a load is done at dequeue. A two-item queue sits between the command
// decode and the back end, so busy rises only when that queue is full.
// A miss pushes the new pair to the front of the TLB and drops the oldest.
// Reset empties the TLB and the queue; the page table is not cleared, and a
// miss on a page never loaded returns an undefined frame.
`default_nettype none

module tlb_fifo_address_translator_top
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire tlbfifo_pkg::request_t request,
    output logic                     done,
    output tlbfifo_pkg::result_t     result
);
    import tlbfifo_pkg::*;

    head_t head;   // queue head towards the back end
    logic  pop;

    // decode and queue
    tlbfifo_front u_front
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .request (request),
        .busy    (busy),
        .head    (head),
        .pop     (pop)
    );

    // TLB search, page table and FIFO replacement
    tlbfifo_back u_back
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .head   (head),
        .pop    (pop),
        .done   (done),
        .result (result)
    );

endmodule : tlb_fifo_address_translator_top

`default_nettype wire

[src/tlbfifo_front.sv]
`default_nettype none

module tlbfifo_front
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire tlbfifo_pkg::request_t request,
    output logic                     busy,
    output tlbfifo_pkg::head_t       head,
    input  wire logic                pop
);
    import tlbfifo_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    entry_t             q_mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    entry_t             new_entry;
    logic               push;

    // decode: split the request into page and payload byte
    always_comb
    begin
        new_entry.kind = cmd_e'(request.command);
        if (request.command == CMD_XLATE)
        begin
            new_entry.page = request.logical_address[ADDR_BITS-1:OFFSET_BITS];
            new_entry.data = DATA_BITS'(request.logical_address[OFFSET_BITS-1:0]);
        end
        else
        begin
            new_entry.page = request.load_page;
            new_entry.data = DATA_BITS'(request.load_frame);
        end
    end

    assign busy = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign push = start && !busy;

    assign head.valid = (count_reg != '0);
    assign head.entry = q_mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem_reg[wr_ptr_reg] <= new_entry;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("queue count overflow");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head.valid)
        else $error("pop from empty queue");

    a_push_fills: assert property (@(posedge clk) disable iff (!rst_n)
        push |=> (count_reg != '0))
        else $error("pushed item lost");

endmodule : tlbfifo_front

`default_nettype wire

[src/tlbfifo_back.sv]
`default_nettype none

module tlbfifo_back
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire tlbfifo_pkg::head_t  head,
    output logic                     pop,
    output logic                     done,
    output tlbfifo_pkg::result_t     result
);
    import tlbfifo_pkg::*;

    typedef enum logic
    {
        S_IDLE,
        S_LOOK
    } state_t;

    state_t                 state_reg;
    entry_t                 item_reg;
    logic                   done_reg;
    result_t                result_reg;
    logic [PAGE_BITS-1:0]   tlb_page_reg  [TLB_ENTRIES];
    logic [PAGE_BITS-1:0]   tlb_frame_reg [TLB_ENTRIES];
    logic [TLB_ENTRIES-1:0] tlb_valid_reg;

    logic [PAGE_BITS-1:0]   pt_mem [PAGE_COUNT];
    logic [PAGE_BITS-1:0]   pt_rd_reg;

    logic                   hit;
    logic [PAGE_BITS-1:0]   hit_frame;
    logic [PAGE_BITS-1:0]   frame;

    assign pop = (state_reg == S_IDLE) && head.valid;

    // page table: loads write at pop, every pop reads ahead for a possible miss
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            if (head.entry.kind == CMD_LOAD)
            begin
                pt_mem[head.entry.page] <= head.entry.data[PAGE_BITS-1:0];
            end
            pt_rd_reg <= pt_mem[head.entry.page];
        end
    end

    // TLB search, frontmost valid match wins
    always_comb
    begin
        hit       = 1'b0;
        hit_frame = '0;
        for (int k = TLB_ENTRIES - 1; k >= 0; k--)
        begin
            if (tlb_valid_reg[k] && (tlb_page_reg[k] == item_reg.page))
            begin
                hit       = 1'b1;
                hit_frame = tlb_frame_reg[k];
            end
        end
    end

    assign frame = hit ? hit_frame : pt_rd_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            done_reg      <= 1'b0;
            item_reg      <= '0;
            result_reg    <= '0;
            tlb_valid_reg <= '0;
            for (int k = 0; k < TLB_ENTRIES; k++)
            begin
                tlb_page_reg[k]  <= '0;
                tlb_frame_reg[k] <= '0;
            end
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (pop && (head.entry.kind == CMD_XLATE))
                    begin
                        item_reg  <= head.entry;
                        state_reg <= S_LOOK;
                    end
                end
                S_LOOK:
                begin
                    done_reg                    <= 1'b1;
                    result_reg.tlb_hit          <= hit;
                    result_reg.physical_address <=
                        {frame, item_reg.data[OFFSET_BITS-1:0]};
                    if (!hit)
                    begin
                        for (int k = TLB_ENTRIES - 1; k > 0; k--)
                        begin
                            tlb_page_reg[k]  <= tlb_page_reg[k-1];
                            tlb_frame_reg[k] <= tlb_frame_reg[k-1];
                            tlb_valid_reg[k] <= tlb_valid_reg[k-1];
                        end
                        tlb_page_reg[0]  <= item_reg.page;
                        tlb_frame_reg[0] <= pt_rd_reg;
                        tlb_valid_reg[0] <= 1'b1;
                    end
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

    a_look_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LOOK) |=> done_reg)
        else $error("lookup gave no result");

    a_done_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("result strobe longer than one cycle");

    a_valid_packed: assert property (@(posedge clk) disable iff (!rst_n)
        (tlb_valid_reg & (tlb_valid_reg + TLB_ENTRIES'(1))) == '0)
        else $error("TLB valid bits not filled from the front");

    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (state_reg == S_IDLE))
        else $error("pop while busy");

endmodule : tlbfifo_back

`default_nettype wire
